// File: sv/gda_pkg.sv
package gda_pkg;

    localparam logic [2:0] KIND_DAYS    = 3'd0;
    localparam logic [2:0] KIND_WEEKS   = 3'd1;
    localparam logic [2:0] KIND_MONTHS  = 3'd2;
    localparam logic [2:0] KIND_YEARS   = 3'd3;
    localparam logic [2:0] KIND_DECADES = 3'd4;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // reciprocals: floor(y/25) = (y*RECIP_25) >> 21 for 16-bit y,
    // floor(x/3) = (x*RECIP_3) >> 15 for 14-bit x
    localparam logic [16:0] RECIP_25 = 17'd83887;
    localparam logic [13:0] RECIP_3  = 14'd10923;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_YEAR_Q,
        OP_YEAR_R,
        OP_CLAMP,
        OP_STEP,
        OP_MON_Q,
        OP_MON_APPLY,
        OP_YEARS,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_days;
        logic is_months;
        logic is_years;
        logic day_done;
    } dp_status_t;

    // y divisible by 400 <=> y % 16 == 0 and y % 25 == 0
    function automatic logic is_leap(input logic [3:0] y_low, input logic [4:0] r25);
        is_leap = (y_low[1:0] == 2'd0) && ((r25 != 5'd0) || (y_low == 4'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        unique case (m) inside
            MONTH_FEB:                  month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
            default:                    month_len = 5'd31;
        endcase
    endfunction

endpackage

// File: sv/gda_dp.sv
module gda_dp (
    input  logic                 aclk,
    input  gda_pkg::dp_cmd_t     cmd,
    input  logic [2:0]           kind_i,
    input  logic [14:0]          amount_i,
    input  logic [4:0]           day_i,
    input  logic [3:0]           month_i,
    input  logic [15:0]          year_i,
    output gda_pkg::dp_status_t  status,
    output logic [4:0]           day_o,
    output logic [3:0]           month_o,
    output logic [15:0]          year_o
);

    logic [2:0]  kind_reg,  kind_next;
    logic [17:0] n_reg,     n_next;
    logic [4:0]  d_reg,     d_next;
    logic [3:0]  m_reg,     m_next;
    logic [15:0] y_reg,     y_next;
    logic [11:0] q_reg,     q_next;
    logic [4:0]  r25_reg,   r25_next;
    logic [4:0]  dout_reg,  dout_next;
    logic [3:0]  mout_reg,  mout_next;
    logic [15:0] yout_reg,  yout_next;

    logic        leap_y, leap_y1;
    logic [15:0] y_inc;
    logic [4:0]  r25_inc;
    logic [4:0]  len, left;
    logic [8:0]  ylen;
    logic [15:0] mon_t;
    logic [27:0] mon_prod;
    logic [32:0] yr_prod;
    logic [15:0] q25, q12;
    logic [17:0] amt7;
    logic [15:0] amt10;

    always_comb begin
        leap_y   = gda_pkg::is_leap(y_reg[3:0], r25_reg);
        y_inc    = y_reg + 16'd1;
        r25_inc  = ((y_reg == 16'hFFFF) || (r25_reg == 5'd24)) ? 5'd0 : r25_reg + 5'd1;
        leap_y1  = gda_pkg::is_leap(y_inc[3:0], r25_inc);
        len      = gda_pkg::month_len(m_reg, leap_y);
        left     = len - d_reg;
        ylen     = ((m_reg <= gda_pkg::MONTH_FEB) ? leap_y : leap_y1) ? 9'd366 : 9'd365;
        mon_t    = 16'(m_reg) - 16'd1 + 16'(n_reg[14:0]);
        mon_prod = mon_t[15:2] * gda_pkg::RECIP_3;
        yr_prod  = y_reg * gda_pkg::RECIP_25;
        q25      = 16'({q_reg, 4'b0000}) + 16'({q_reg, 3'b000}) + 16'(q_reg);
        q12      = 16'({q_reg, 3'b000}) + 16'({q_reg, 2'b00});
        amt7     = 18'({amount_i, 3'b000}) - 18'(amount_i);
        amt10    = 16'({n_reg[14:0], 3'b000}) + 16'({n_reg[14:0], 1'b0});

        status.is_days   = (kind_reg == gda_pkg::KIND_DAYS) || (kind_reg == gda_pkg::KIND_WEEKS);
        status.is_months = (kind_reg == gda_pkg::KIND_MONTHS);
        status.is_years  = (kind_reg == gda_pkg::KIND_YEARS) ||
                           (kind_reg == gda_pkg::KIND_DECADES);
        status.day_done  = (n_reg <= 18'(left));

        kind_next = kind_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        m_next    = m_reg;
        y_next    = y_reg;
        q_next    = q_reg;
        r25_next  = r25_reg;
        dout_next = dout_reg;
        mout_next = mout_reg;
        yout_next = yout_reg;

        unique case (cmd.op)
            gda_pkg::OP_NONE: begin
            end
            gda_pkg::OP_LOAD: begin
                kind_next = kind_i;
                n_next    = (kind_i == gda_pkg::KIND_WEEKS) ? amt7 : 18'(amount_i);
                d_next    = (day_i == 5'd0) ? 5'd1 : day_i;
                if (month_i == 4'd0) begin
                    m_next = 4'd1;
                end else if (month_i > gda_pkg::MONTH_DEC) begin
                    m_next = gda_pkg::MONTH_DEC;
                end else begin
                    m_next = month_i;
                end
                y_next = year_i;
            end
            gda_pkg::OP_YEAR_Q: begin
                q_next = yr_prod[32:21];
            end
            gda_pkg::OP_YEAR_R: begin
                r25_next = 5'(y_reg - q25);
            end
            gda_pkg::OP_CLAMP: begin
                if (d_reg > len) begin
                    d_next = len;
                end
            end
            gda_pkg::OP_STEP: begin
                if (status.day_done) begin
                    d_next = d_reg + 5'(n_reg);
                end else if ((d_reg == 5'd1) && (n_reg >= 18'(ylen))) begin
                    n_next   = n_reg - 18'(ylen);
                    y_next   = y_inc;
                    r25_next = r25_inc;
                end else begin
                    n_next = n_reg - 18'(left) - 18'd1;
                    d_next = 5'd1;
                    if (m_reg == gda_pkg::MONTH_DEC) begin
                        m_next   = 4'd1;
                        y_next   = y_inc;
                        r25_next = r25_inc;
                    end else begin
                        m_next = m_reg + 4'd1;
                    end
                end
            end
            gda_pkg::OP_MON_Q: begin
                q_next = mon_prod[26:15];
            end
            gda_pkg::OP_MON_APPLY: begin
                m_next = 4'(mon_t - q12 + 16'd1);
                y_next = y_reg + 16'(q_reg);
            end
            gda_pkg::OP_YEARS: begin
                y_next = y_reg + ((kind_reg == gda_pkg::KIND_DECADES) ?
                                  amt10 : 16'(n_reg[14:0]));
            end
            gda_pkg::OP_PUBLISH: begin
                dout_next = d_reg;
                mout_next = m_reg;
                yout_next = y_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        q_reg    <= q_next;
        r25_reg  <= r25_next;
        dout_reg <= dout_next;
        mout_reg <= mout_next;
        yout_reg <= yout_next;
    end

    assign day_o   = dout_reg;
    assign month_o = mout_reg;
    assign year_o  = yout_reg;

endmodule

// File: sv/gda_ctrl.sv
module gda_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  gda_pkg::dp_status_t  status,
    output gda_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_YEAR_Q,
        ST_YEAR_R,
        ST_CLAMP,
        ST_RUN,
        ST_MON_Q,
        ST_MON_APPLY,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        cmd.op        = gda_pkg::OP_NONE;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = gda_pkg::OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_days) begin
                    state_next = ST_YEAR_Q;
                end else if (status.is_months) begin
                    state_next = ST_MON_Q;
                end else if (status.is_years) begin
                    cmd.op     = gda_pkg::OP_YEARS;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_YEAR_Q: begin
                cmd.op     = gda_pkg::OP_YEAR_Q;
                state_next = ST_YEAR_R;
            end
            ST_YEAR_R: begin
                cmd.op     = gda_pkg::OP_YEAR_R;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.op     = gda_pkg::OP_CLAMP;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                cmd.op = gda_pkg::OP_STEP;
                if (status.day_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_MON_Q: begin
                cmd.op     = gda_pkg::OP_MON_Q;
                state_next = ST_MON_APPLY;
            end
            ST_MON_APPLY: begin
                cmd.op     = gda_pkg::OP_MON_APPLY;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = gda_pkg::OP_PUBLISH;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction did not start decode");

    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == gda_pkg::OP_PUBLISH) |=> m_tvalid_reg)
        else $error("published result not presented");

    a_run_days_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> status.is_days)
        else $error("day stepping entered for a non-day kind");

    a_finish_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_tvalid_reg && !m_tready) |=>
        (state_reg == ST_FINISH && m_tvalid_reg))
        else $error("result overwritten while output stalled");

endmodule

// File: sv/gregorian_date_adder_core.sv
// Gregorian date adder: advances (day, month, year) by an amount of days,
// weeks, months, years or decades.
// Input channel s_*: one transaction per date; s_tuser carries the kind,
// s_tdata carries amount, day, month and year.
// Output channel m_*: one transaction per input with the resulting date.
// Path from input acceptance to m_tvalid: years/decades and unused kinds
//   go from decode to finish, months pass the quotient and apply states,
//   days/weeks pass the year quotient, year remainder and clamp states and
//   then the day walker; each walker step before the last rolls one month
//   or skips one whole year.
// One date is in flight at a time; s_tready is high only while idle, and a
// new transaction is taken in the cycle after the previous result is
// published, even while that result still waits in the output register.
// If the receiver stalls, the finished date waits inside until the output
// register frees up.
// Reset (aresetn low, synchronous) returns to idle and drops m_tvalid.
module gregorian_date_adder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // amount[14:0], day_in[19:15], month_in[23:20], year_in[39:24]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // day_out[4:0], month_out[8:5], year_out[24:9], zero[31:25]
);

    gda_pkg::dp_cmd_t    cmd;
    gda_pkg::dp_status_t status;
    logic [4:0]          day_out;
    logic [3:0]          month_out;
    logic [15:0]         year_out;

    gda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gda_dp u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .kind_i   (s_tuser),
        .amount_i (s_tdata[14:0]),
        .day_i    (s_tdata[19:15]),
        .month_i  (s_tdata[23:20]),
        .year_i   (s_tdata[39:24]),
        .status   (status),
        .day_o    (day_out),
        .month_o  (month_out),
        .year_o   (year_out)
    );

    assign m_tdata = {7'd0, year_out, month_out, day_out};

endmodule
